// ===== hw/rtl/ralu_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package ralu_pkg;
    localparam int OPW  = 16;        // operand width
    localparam int PW   = 2 * OPW;   // product width
    localparam int SW   = PW + 2;    // width of the sum of two products
    localparam int MW   = 32;        // magnitude width of the terms
    localparam int NUMW = 33;        // result numerator width
    localparam int DENW = 32;        // result denominator width
    localparam int KW   = 5;         // shift count of the common power of two
    localparam int CW   = 5;         // divider bit counter

    localparam logic [CW-1:0] DIV_LAST = CW'(MW - 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GCD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic num_zero;
        logic gcd_done;
        logic div_last;
    } t_stat;
endpackage
`default_nettype wire

// ===== hw/rtl/ralu_if.sv =====
// Handshake interfaces for the operand and result channels.
`default_nettype none
interface ralu_in_if;
    import ralu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic signed [OPW-1:0] num_a;
    logic signed [OPW-1:0] den_a;
    logic signed [OPW-1:0] num_b;
    logic signed [OPW-1:0] den_b;
    modport source (output valid, operation, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, operation, num_a, den_a, num_b, den_b, output ready);
endinterface

interface ralu_out_if;
    import ralu_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [NUMW-1:0] result_num;
    logic signed [DENW-1:0] result_den;
    logic                   zero_den_error;
    modport source (output valid, result_num, result_den, zero_den_error, input ready);
    modport sink   (input valid, result_num, result_den, zero_den_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ralu_ctrl.sv =====
// Sequencer for the rational unit: products, sum, binary GCD, division, output.
`default_nettype none
module ralu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_free,
    input  wire ralu_pkg::t_stat i_stat,
    output ralu_pkg::t_cmd      o_cmd,
    output logic                o_in_ready
);
    import ralu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MUL;
            S_MUL:  n_state = i_stat.err ? S_OUT : S_SUM;
            S_SUM:  n_state = S_GCD;
            S_GCD: begin
                if (i_stat.num_zero)      n_state = S_OUT;
                else if (i_stat.gcd_done) n_state = S_DIV;
            end
            S_DIV:  if (i_stat.div_last) n_state = S_OUT;
            S_OUT:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_SUM: o_cmd.sum = 1'b1;
            S_GCD: begin
                o_cmd.gcd_step = !i_stat.num_zero && !i_stat.gcd_done;
                o_cmd.div_init = !i_stat.num_zero && i_stat.gcd_done;
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_OUT: o_cmd.out_load = i_out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ralu_dp.sv =====
// Datapath: cross products, signed sum, binary GCD and a pair of restoring dividers.
`default_nettype none
module ralu_dp (
    input  wire logic                          i_clk,
    input  wire ralu_pkg::t_cmd                i_cmd,
    input  wire logic [1:0]                    i_operation,
    input  wire logic signed [ralu_pkg::OPW-1:0] i_num_a,
    input  wire logic signed [ralu_pkg::OPW-1:0] i_den_a,
    input  wire logic signed [ralu_pkg::OPW-1:0] i_num_b,
    input  wire logic signed [ralu_pkg::OPW-1:0] i_den_b,
    output ralu_pkg::t_stat                    o_stat,
    output logic signed [ralu_pkg::NUMW-1:0]   o_result_num,
    output logic signed [ralu_pkg::DENW-1:0]   o_result_den,
    output logic                               o_zero_den_error
);
    import ralu_pkg::*;

    t_op                   r_op;
    logic signed [OPW-1:0] r_na, r_da, r_nb, r_db;
    logic                  r_err;
    logic signed [PW-1:0]  r_p1, r_p2, r_pd;
    logic                  r_nneg, r_dneg;
    logic [MW-1:0]         r_nmag, r_dmag;
    logic [MW-1:0]         r_ga, r_gb;
    logic [KW-1:0]         r_k;
    logic [MW-1:0]         r_div;
    logic [MW-1:0]         r_qn, r_qd, r_rn, r_rd;
    logic [CW-1:0]         r_cnt;

    logic signed [SW-1:0] sum_v;
    logic signed [PW-1:0] nd_v;
    logic [MW-1:0]        nmag_v, dmag_v;
    logic [MW:0]          trial_n, trial_d;
    logic                 qbit_n, qbit_d;
    logic [MW-1:0]        neg_q_d;
    logic [NUMW-1:0]      num_ext;

    always_comb begin
        unique case (r_op)
            OP_ADD:  sum_v = SW'(r_p1) + SW'(r_p2);
            OP_SUB:  sum_v = SW'(r_p1) - SW'(r_p2);
            default: sum_v = SW'(r_p1);
        endcase
        nmag_v = sum_v[SW-1] ? MW'(-sum_v) : MW'(sum_v);
        nd_v   = r_pd;
        dmag_v = nd_v[PW-1] ? MW'(-nd_v) : MW'(nd_v);
    end

    // One restoring step for each term, sharing the divisor.
    always_comb begin
        trial_n = {r_rn, r_qn[MW-1]} - {1'b0, r_div};
        trial_d = {r_rd, r_qd[MW-1]} - {1'b0, r_div};
        qbit_n  = !trial_n[MW];
        qbit_d  = !trial_d[MW];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_na  <= i_num_a;
            r_da  <= i_den_a;
            r_nb  <= i_num_b;
            r_db  <= i_den_b;
            r_err <= (i_den_a == '0) || (i_den_b == '0) ||
                     ((t_op'(i_operation) == OP_DIV) && (i_num_b == '0));
        end
        if (i_cmd.mul) begin
            r_p1 <= PW'(r_na) * PW'((r_op == OP_MUL) ? r_nb : r_db);
            r_p2 <= PW'(r_nb) * PW'(r_da);
            r_pd <= PW'(r_da) * PW'((r_op == OP_DIV) ? r_nb : r_db);
        end
        if (i_cmd.sum) begin
            r_nneg <= sum_v[SW-1];
            r_nmag <= nmag_v;
            r_dneg <= nd_v[PW-1];
            r_dmag <= dmag_v;
            r_ga   <= nmag_v;
            r_gb   <= dmag_v;
            r_k    <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_k  <= r_k + 1'b1;
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_init) begin
            r_div <= (r_ga | r_gb) << r_k;
            r_qn  <= r_nmag;
            r_qd  <= r_dmag;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rn  <= qbit_n ? trial_n[MW-1:0] : {r_rn[MW-2:0], r_qn[MW-1]};
            r_rd  <= qbit_d ? trial_d[MW-1:0] : {r_rd[MW-2:0], r_qd[MW-1]};
            r_qn  <= {r_qn[MW-2:0], qbit_n};
            r_qd  <= {r_qd[MW-2:0], qbit_d};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        o_stat.err      = r_err;
        o_stat.num_zero = (r_nmag == '0);
        o_stat.gcd_done = (r_ga == '0) || (r_gb == '0);
        o_stat.div_last = (r_cnt == DIV_LAST);
    end

    always_comb begin
        num_ext = NUMW'(r_qn);
        neg_q_d = -r_qd;
        if (r_err) begin
            o_result_num = '0;
            o_result_den = '0;
        end else if (r_nmag == '0) begin
            o_result_num = '0;
            o_result_den = DENW'(1);
        end else begin
            o_result_num = r_nneg ? -num_ext : num_ext;
            o_result_den = r_dneg ? DENW'(neg_q_d) : DENW'(r_qd);
        end
        o_zero_den_error = r_err;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rational_alu_with_gcd_reduce.sv =====
// Top level of the rational arithmetic unit with GCD reduction.
//   channel  | dir | payload
//   i_in     | in  | operation, num_a, den_a, num_b, den_b
//   o_res    | out | result_num, result_den, zero_den_error
// One transaction at a time. With a zero denominator or a division by zero it goes
// from accept and the products straight to the output load; with a zero numerator
// it leaves the GCD state for the output load. Otherwise it runs accept, products,
// sum, binary GCD (one shift or subtract a cycle), divider setup, division, output.
// The result sits in an output register, so a stalled output holds only the last
// step; reset (synchronous, active low) empties the unit and the output register.
`default_nettype none
module rational_alu_with_gcd_reduce (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ralu_in_if.sink   i_in,
    ralu_out_if.source o_res
);
    import ralu_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_free;
    logic  r_o_valid;
    logic signed [NUMW-1:0] dp_num, r_o_num;
    logic signed [DENW-1:0] dp_den, r_o_den;
    logic dp_err, r_o_err;

    assign out_free = !r_o_valid || o_res.ready;

    ralu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready)
    );

    ralu_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_operation      (i_in.operation),
        .i_num_a          (i_in.num_a),
        .i_den_a          (i_in.den_a),
        .i_num_b          (i_in.num_b),
        .i_den_b          (i_in.den_b),
        .o_stat           (stat),
        .o_result_num     (dp_num),
        .o_result_den     (dp_den),
        .o_zero_den_error (dp_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_o_num <= dp_num;
            r_o_den <= dp_den;
            r_o_err <= dp_err;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.result_num     = r_o_num;
    assign o_res.result_den     = r_o_den;
    assign o_res.zero_den_error = r_o_err;

`ifndef SYNTHESIS
    // An error result carries zero terms.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_den_error) |->
            (o_res.result_num == '0 && o_res.result_den == '0))
        else $error("error result with nonzero terms");

    // A good result never has a zero denominator.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.zero_den_error) |-> (o_res.result_den != '0))
        else $error("zero denominator in a good result");

    // The unit holds one transaction at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while busy");
`endif
endmodule
`default_nettype wire
